### src/kms_pkg.sv
// ----------------------------------------------------------------------------
// kms_pkg: shared types and constants of the keyed minute statistic aggregator
// Holds the stored entry layout, the status codes and the reciprocal
// constants for the divisions by 60, 10000 and 100.
// ----------------------------------------------------------------------------
package kms_pkg;

  typedef enum logic [2:0] {
    ST_INSERTED   = 3'd0,
    ST_MERGED     = 3'd1,
    ST_BAD_LENGTH = 3'd2,
    ST_MISMATCH   = 3'd3,
    ST_UNKNOWN    = 3'd4,
    ST_FLUSHED    = 3'd5
  } status_t;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_ENTRY  = 1'b1;

  localparam logic [1:0] REG_MAX = 2'd0;
  localparam logic [1:0] REG_MIN = 2'd1;
  localparam logic [1:0] REG_SET = 2'd2;
  localparam logic [1:0] REG_SUM = 2'd3;

  // floor(x / 60) = (x * DIV60_MUL) >> 37 for every 32-bit x.
  localparam logic [31:0] DIV60_MUL = 32'h8888_8889;
  // floor(x / 10000) = (x * DIV10K_MUL) >> 45 for every 32-bit x.
  localparam logic [31:0] DIV10K_MUL = 32'hD1B7_1759;
  // floor(r / 100) = (r * DIV100_MUL) >> 19 for r below 10000.
  localparam logic [12:0] DIV100_MUL = 13'd5243;

  typedef struct packed {
    logic [31:0] stat_id;
    logic [31:0] minute;
    logic [31:0] value;
    logic [31:0] protocol;
  } entry_t;

endpackage

### src/kms_ram.sv
// ----------------------------------------------------------------------------
// kms_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module kms_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/keyed_minute_stat_aggregator.sv
// ----------------------------------------------------------------------------
// keyed_minute_stat_aggregator: per-minute keyed statistic table
// An update makes one full pass over the entry RAM to look for its key.
// A drain emits one entry per full RAM pass, each pass finding the smallest
// remaining key; a flush of n entries takes n passes.
// One request is worked on at a time; the output register lets a result wait.
// Reset clears the valid bits and the count at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module keyed_minute_stat_aggregator #(
  parameter int CAPACITY = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic        length_ok,
  input  logic [31:0] stat_id,
  input  logic [31:0] timestamp,
  input  logic [31:0] sample_value,
  input  logic [31:0] protocol_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [2:0]  status,
  output logic [31:0] out_stat_id,
  output logic [31:0] out_minute_start,
  output logic [31:0] out_value,
  output logic [31:0] out_protocol_id,
  output logic [6:0]  shard_index,
  output logic [6:0]  table_index,
  output logic        last
);

  import kms_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_KEY1   = 12'b0000_0000_0010,
    S_KEY2   = 12'b0000_0000_0100,
    S_SCAN   = 12'b0000_0000_1000,
    S_APPLY  = 12'b0000_0001_0000,
    S_STATUS = 12'b0000_0010_0000,
    S_DSCAN  = 12'b0000_0100_0000,
    S_D1     = 12'b0000_1000_0000,
    S_D2     = 12'b0001_0000_0000,
    S_D3     = 12'b0010_0000_0000,
    S_D4     = 12'b0100_0000_0000,
    S_DEMIT  = 12'b1000_0000_0000
  } state_t;

  state_t state;

  logic [31:0] max_id, min_id, set_id, sum_id;
  logic [31:0] rid, ts, val, proto;
  logic [63:0] div_prod;
  logic [31:0] minute;

  logic [CW-1:0] scan_cnt;
  logic chk;
  logic [AW-1:0] chk_idx;

  logic hit_found;
  logic [AW-1:0] hit_idx;
  logic [31:0] hit_value, hit_proto;

  logic best_found;
  logic [AW-1:0] best_idx;
  entry_t best;

  logic [CAPACITY-1:0] valid;
  logic [CW-1:0] count;

  status_t st;
  logic st_last, st_drain;

  logic [63:0] d_prod;
  logic [13:0] d_rem;
  logic [26:0] d_prod2;
  logic [6:0] d_shard, d_table;

  logic ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t ram_wdata, ram_rdata;
  logic [$bits(entry_t)-1:0] ram_q;

  logic [AW-1:0] slot;
  logic [31:0] new_value;
  status_t ap_status;
  logic out_free;
  logic out_load;
  logic [26:0] q60;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign out_load = out_free && (state == S_STATUS || state == S_DEMIT);
  assign ram_rdata = entry_t'(ram_q);
  assign q60 = div_prod[63:37];

  kms_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(scan_cnt[AW-1:0]),
    .rdata(ram_q)
  );

  always_comb begin
    logic found;
    found = 1'b0;
    slot = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (!valid[i] && !found) begin
        slot = AW'(i);
        found = 1'b1;
      end
    end
  end

  always_comb begin
    new_value = hit_value;
    ap_status = ST_MERGED;
    if (hit_proto != proto) begin
      ap_status = ST_MISMATCH;
    end else if (proto == max_id) begin
      new_value = (hit_value > val) ? hit_value : val;
    end else if (proto == min_id) begin
      new_value = (hit_value < val) ? hit_value : val;
    end else if (proto == set_id) begin
      new_value = val;
    end else if (proto == sum_id) begin
      new_value = hit_value + val;
    end else begin
      ap_status = ST_UNKNOWN;
    end
  end

  assign ram_we = (state == S_APPLY) && (!hit_found || ap_status == ST_MERGED);
  assign ram_waddr = hit_found ? hit_idx : slot;
  assign ram_wdata = '{stat_id: rid, minute: minute,
                       value: (hit_found ? new_value : val), protocol: proto};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      count <= '0;
      out_valid <= 1'b0;
      chk <= 1'b0;
      max_id <= 32'd0;
      min_id <= 32'd1;
      set_id <= 32'd2;
      sum_id <= 32'd3;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX: max_id <= cfg_data;
          REG_MIN: min_id <= cfg_data;
          REG_SET: set_id <= cfg_data;
          REG_SUM: sum_id <= cfg_data;
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            rid <= stat_id;
            ts <= timestamp;
            val <= sample_value;
            proto <= protocol_id;
            if (operation) begin
              st <= ST_FLUSHED;
              st_last <= (count == '0);
              st_drain <= (count != '0);
              state <= S_STATUS;
            end else if (!length_ok) begin
              st <= ST_BAD_LENGTH;
              st_last <= 1'b1;
              st_drain <= 1'b0;
              state <= S_STATUS;
            end else begin
              state <= S_KEY1;
            end
          end
        end
        S_KEY1: begin
          div_prod <= 64'(ts) * 64'(DIV60_MUL);
          state <= S_KEY2;
        end
        S_KEY2: begin
          minute <= 32'({q60, 6'b0}) - 32'({q60, 2'b0});
          scan_cnt <= '0;
          chk <= 1'b0;
          hit_found <= 1'b0;
          state <= S_SCAN;
        end
        S_SCAN, S_DSCAN: begin
          if (scan_cnt != CAP_C) begin
            scan_cnt <= scan_cnt + ONE_C;
            chk <= 1'b1;
            chk_idx <= scan_cnt[AW-1:0];
          end else begin
            chk <= 1'b0;
          end
          if (state == S_SCAN) begin
            if (chk && valid[chk_idx] && !hit_found && ram_rdata.stat_id == rid &&
                ram_rdata.minute == minute) begin
              hit_found <= 1'b1;
              hit_idx <= chk_idx;
              hit_value <= ram_rdata.value;
              hit_proto <= ram_rdata.protocol;
            end
            if (scan_cnt == CAP_C && !chk) begin
              state <= S_APPLY;
            end
          end else begin
            if (chk && valid[chk_idx] && (!best_found ||
                {ram_rdata.stat_id, ram_rdata.minute} < {best.stat_id, best.minute})) begin
              best_found <= 1'b1;
              best_idx <= chk_idx;
              best <= ram_rdata;
            end
            if (scan_cnt == CAP_C && !chk) begin
              state <= S_D1;
            end
          end
        end
        S_APPLY: begin
          if (hit_found) begin
            st <= ap_status;
            st_last <= 1'b1;
            st_drain <= 1'b0;
          end else begin
            st <= ST_INSERTED;
            valid[slot] <= 1'b1;
            count <= count + ONE_C;
            st_drain <= (count + ONE_C == CAP_C);
            st_last <= (count + ONE_C != CAP_C);
          end
          state <= S_STATUS;
        end
        S_STATUS: begin
          if (out_free) begin
            kind <= KIND_STATUS;
            status <= st;
            out_stat_id <= '0;
            out_minute_start <= '0;
            out_value <= '0;
            out_protocol_id <= '0;
            shard_index <= '0;
            table_index <= '0;
            last <= st_last;
            if (st_drain) begin
              scan_cnt <= '0;
              chk <= 1'b0;
              best_found <= 1'b0;
              state <= S_DSCAN;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_D1: begin
          d_prod <= 64'(best.stat_id) * 64'(DIV10K_MUL);
          state <= S_D2;
        end
        S_D2: begin
          d_rem <= 14'(best.stat_id - 32'(d_prod[63:45]) * 32'd10000);
          state <= S_D3;
        end
        S_D3: begin
          d_prod2 <= 27'(d_rem) * 27'(DIV100_MUL);
          state <= S_D4;
        end
        S_D4: begin
          d_shard <= d_prod2[25:19];
          d_table <= 7'(d_rem - 14'(d_prod2[25:19]) * 14'd100);
          state <= S_DEMIT;
        end
        S_DEMIT: begin
          if (out_free) begin
            kind <= KIND_ENTRY;
            status <= ST_FLUSHED;
            out_stat_id <= best.stat_id;
            out_minute_start <= best.minute;
            out_value <= best.value;
            out_protocol_id <= best.protocol;
            shard_index <= d_shard;
            table_index <= d_table;
            last <= (count == ONE_C);
            valid[best_idx] <= 1'b0;
            count <= count - ONE_C;
            if (count == ONE_C) begin
              state <= S_IDLE;
            end else begin
              scan_cnt <= '0;
              chk <= 1'b0;
              best_found <= 1'b0;
              state <= S_DSCAN;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for keyed_minute_stat_aggregator
// Requests are queued by the stimulus thread and driven on the falling edge.
// A behavioral table model predicts every status and drained entry, and the
// monitor compares the results in order, through several register settings
// and idle and stall phases.
// ----------------------------------------------------------------------------
module tb;
  import kms_pkg::*;

  localparam int CAP = 32;
  localparam int WDOG_LIMIT = 20000;

  typedef struct packed {
    logic        operation;
    logic        length_ok;
    logic [31:0] stat_id;
    logic [31:0] timestamp;
    logic [31:0] sample_value;
    logic [31:0] protocol_id;
  } request_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic [31:0] stat_id;
    logic [31:0] minute;
    logic [31:0] value;
    logic [31:0] protocol;
    logic [6:0]  shard;
    logic [6:0]  tbl;
    logic        last;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_MAX;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic operation = 1'b0;
  logic length_ok = 1'b0;
  logic [31:0] stat_id = '0;
  logic [31:0] timestamp = '0;
  logic [31:0] sample_value = '0;
  logic [31:0] protocol_id = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic kind;
  logic [2:0] status;
  logic [31:0] out_stat_id, out_minute_start, out_value, out_protocol_id;
  logic [6:0] shard_index, table_index;
  logic last;

  keyed_minute_stat_aggregator dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state.
  logic [31:0] proto_reg [4];
  logic        tab_valid [CAP];
  logic [63:0] tab_key [CAP];
  logic [31:0] tab_value [CAP];
  logic [31:0] tab_proto [CAP];
  int          tab_count;

  request_t pending_requests [$];
  outcome_t expected_results [$];
  int mismatches = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  bit done = 0;
  bit in_accepted = 0;

  function automatic outcome_t status_result(status_t st);
    outcome_t r;
    r = '0;
    r.kind = KIND_STATUS;
    r.status = st;
    return r;
  endfunction

  task automatic drain_table();
    int best;
    outcome_t r;
    forever begin
      best = -1;
      for (int i = 0; i < CAP; i++)
        if (tab_valid[i] && (best < 0 || tab_key[i] < tab_key[best])) best = i;
      if (best < 0) break;
      r = '0;
      r.kind = KIND_ENTRY;
      r.status = ST_FLUSHED;
      r.stat_id = tab_key[best][63:32];
      r.minute = tab_key[best][31:0];
      r.value = tab_value[best];
      r.protocol = tab_proto[best];
      r.shard = 7'((r.stat_id % 10000) / 100);
      r.tbl = 7'(r.stat_id % 100);
      expected_results.push_back(r);
      tab_valid[best] = 1'b0;
    end
    tab_count = 0;
  endtask

  task automatic predict_request(request_t q);
    logic [63:0] key;
    int hit, slot;
    status_t st;
    logic [31:0] cur;
    if (q.operation) begin
      expected_results.push_back(status_result(ST_FLUSHED));
      drain_table();
    end else if (!q.length_ok) begin
      expected_results.push_back(status_result(ST_BAD_LENGTH));
    end else begin
      key = {q.stat_id, q.timestamp / 60 * 60};
      hit = -1;
      slot = -1;
      for (int i = 0; i < CAP; i++) begin
        if (tab_valid[i]) begin
          if (tab_key[i] == key && hit < 0) hit = i;
        end else if (slot < 0) begin
          slot = i;
        end
      end
      if (hit >= 0) begin
        cur = tab_value[hit];
        st = ST_MERGED;
        if (tab_proto[hit] != q.protocol_id) st = ST_MISMATCH;
        else if (q.protocol_id == proto_reg[REG_MAX])
          tab_value[hit] = cur > q.sample_value ? cur : q.sample_value;
        else if (q.protocol_id == proto_reg[REG_MIN])
          tab_value[hit] = cur < q.sample_value ? cur : q.sample_value;
        else if (q.protocol_id == proto_reg[REG_SET]) tab_value[hit] = q.sample_value;
        else if (q.protocol_id == proto_reg[REG_SUM]) tab_value[hit] = cur + q.sample_value;
        else st = ST_UNKNOWN;
        expected_results.push_back(status_result(st));
      end else begin
        if (slot >= 0) begin
          tab_valid[slot] = 1'b1;
          tab_key[slot] = key;
          tab_value[slot] = q.sample_value;
          tab_proto[slot] = q.protocol_id;
          tab_count++;
        end
        expected_results.push_back(status_result(ST_INSERTED));
        if (tab_count >= CAP) drain_table();
      end
    end
    expected_results[$].last = 1'b1;
  endtask

  // Driver.
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_accepted)) begin
      if (pending_requests.size() > 0 && $urandom_range(99) >= idle_pct) begin
        request_t q;
        q = pending_requests.pop_front();
        in_valid <= 1'b1;
        {operation, length_ok, stat_id, timestamp, sample_value, protocol_id} <= q;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Monitor and prediction at acceptance.
  always @(posedge clk) begin
    if (!rst) begin
      in_accepted <= in_valid && !in_stall;
      if (in_valid && !in_stall)
        predict_request({operation, length_ok, stat_id, timestamp, sample_value,
                         protocol_id});
      if (out_valid && !out_stall) begin
        outcome_t got, exp;
        got = {kind, status, out_stat_id, out_minute_start, out_value,
               out_protocol_id, shard_index, table_index, last};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result %h", got);
        end else begin
          exp = expected_results.pop_front();
          if (got !== exp) begin
            mismatches++;
            if (mismatches <= 10) $display("Mismatch: expected %h, got %h", exp, got);
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_LIMIT && !done) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic request_t make_update(logic [31:0] id, logic [31:0] ts,
                                           logic [31:0] val, logic [31:0] pr);
    return {1'b0, 1'b1, id, ts, val, pr};
  endfunction

  task automatic wait_idle();
    while (pending_requests.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (CAP * 40 + 50) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    proto_reg[idx] = val;
  endtask

  task automatic random_phase(int n, int ip, int sp, logic [31:0] pmask);
    request_t q;
    logic [31:0] ids [4];
    idle_pct = ip;
    stall_pct = sp;
    for (int i = 0; i < 4; i++) ids[i] = $urandom_range(3) == 0 ? $urandom : $urandom_range(40);
    for (int i = 0; i < n; i++) begin
      q = make_update(ids[$urandom_range(3)], $urandom_range(299),
                      $urandom, $urandom_range(4) & pmask);
      case ($urandom_range(19))
        0: q.operation = 1'b1;
        1: q.length_ok = 1'b0;
        2: q = {2'($urandom), 32'($urandom), 32'($urandom), 32'($urandom), 32'($urandom)};
        3: q.stat_id = $urandom;
        default: ;
      endcase
      if (pmask == '1 && $urandom_range(3) == 0) q.protocol_id = $urandom;
      pending_requests.push_back(q);
    end
  endtask

  initial begin
    proto_reg[REG_MAX] = 0;
    proto_reg[REG_MIN] = 1;
    proto_reg[REG_SET] = 2;
    proto_reg[REG_SUM] = 3;
    for (int i = 0; i < CAP; i++) tab_valid[i] = 1'b0;
    tab_count = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: each merge kind, mismatch, unknown, bad length, extremes, flush.
    pending_requests.push_back(make_update(32'd12345, 32'd59, 32'd7, 32'd0));
    pending_requests.push_back(make_update(32'd12345, 32'd0, 32'd9, 32'd0));
    pending_requests.push_back(make_update(32'd12345, 32'd30, 32'd3, 32'd0));
    pending_requests.push_back(make_update(32'd5, 32'd60, 32'd10, 32'd1));
    pending_requests.push_back(make_update(32'd5, 32'd119, 32'd4, 32'd1));
    pending_requests.push_back(make_update(32'd6, 32'd120, 32'd10, 32'd2));
    pending_requests.push_back(make_update(32'd6, 32'd121, 32'd44, 32'd2));
    pending_requests.push_back(make_update('1, '1, '1, 32'd3));
    pending_requests.push_back(make_update('1, 32'hFFFF_FFC4, 32'd2, 32'd3));
    pending_requests.push_back(make_update(32'd5, 32'd61, 32'd1, 32'd3));
    pending_requests.push_back(make_update(32'd7, 32'd0, 32'd1, 32'hDEAD_BEEF));
    pending_requests.push_back(make_update(32'd7, 32'd1, 32'd1, 32'hDEAD_BEEF));
    pending_requests.push_back({1'b0, 1'b0, 96'('1), 32'('1)});
    pending_requests.push_back({1'b1, 1'b0, 128'('1)});
    pending_requests.push_back({1'b1, 1'b1, 128'd0});
    for (int i = 0; i < CAP; i++)
      pending_requests.push_back(make_update(32'(CAP - i), 32'd600, 32'(i), 32'd3));
    wait_idle();

    random_phase(90, 0, 0, 32'h7);
    wait_idle();
    write_reg(REG_MAX, '1);
    write_reg(REG_MIN, '1);
    write_reg(REG_SET, 32'd0);
    write_reg(REG_SUM, 32'hFFFF_FFFE);
    random_phase(80, 66, 0, '1);
    wait_idle();
    write_reg(REG_MAX, 32'd4);
    write_reg(REG_MIN, 32'd2);
    write_reg(REG_SET, 32'd1);
    write_reg(REG_SUM, 32'd0);
    random_phase(80, 0, 66, 32'h7);
    wait_idle();
    random_phase(80, 28, 28, 32'h7);
    wait_idle();
    random_phase(60, 0, 0, 32'h7);
    wait_idle();
    done = 1;
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
